@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DATA_W = 32;
  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } deq_cmd_t;

endpackage : deq_pkg

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit values in a ring of DEPTH entries; one result
// (front, back, count, drop flag) per operation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | fields
//  in_     | input     | in_valid/in_stall  | mode, value
//  out_    | output    | out_valid/out_stall| front_value, back_value,
//          |           |                    | entry_count, push_dropped
//
//  An operation steps through accept, pointer update and ring write,
//  dual-port ring read and result load; the ring read is registered.
//  The next beat is accepted while a result waits in the output register.
//  Reset clears pointers, count and drop flag; the ring holds no reset value.
//  A stalled output holds the sequencer in its load step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [deq_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [deq_pkg::DATA_W-1:0]      out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0]      out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]             out_entry_count,
  output logic                                   out_push_dropped
);

  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_push_dropped (out_push_dropped)
  );

endmodule : double_ended_queue

`default_nettype wire

@@ hw/rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM, one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule : deq_ram

`default_nettype wire

@@ hw/rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept, execute, read, load result; owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output deq_pkg::deq_cmd_t      cmd
);

  import deq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.load    = (state_r == S_LOAD) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC:  state_nxt = S_READ;
      S_READ:  state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : deq_ctrl

`default_nettype wire

@@ hw/rtl/deq_dp.sv @@
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring pointers, entry store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire deq_pkg::deq_cmd_t                cmd,
  input  wire logic [deq_pkg::MODE_W-1:0]       in_mode,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic signed [deq_pkg::DATA_W-1:0]     out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0]     out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]            out_entry_count,
  output logic                                  out_push_dropped
);

  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [MODE_W-1:0]        mode_r;
  logic [DATA_W-1:0]        value_r;
  logic [IW-1:0]            front_r, front_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     dropped_r, dropped_nxt;
  logic                     we;
  logic [IW-1:0]            waddr;
  logic [IW-1:0]            back_addr;
  logic [DATA_W-1:0]        rdata_a, rdata_b;
  logic                     full, empty;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offset);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
    return (idx == '0) ? IW'(DEPTH - 1) : idx - IW'(1);
  endfunction

  assign full  = (count_r == FULL_COUNT);
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    we          = 1'b0;
    waddr       = wrap_add(front_r, count_r);
    if (cmd.exec) begin
      dropped_nxt = 1'b0;
      case (mode_r)
        MODE_PUSH_BACK: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_PUSH_FRONT: begin
          waddr = wrap_dec(front_r);
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            front_nxt = waddr;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (!empty) begin
            front_nxt = wrap_add(front_r, CW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (!empty) count_nxt = count_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // read addresses settle in the cycle after the update
  assign back_addr = wrap_add(front_r, count_r - CW'(1));

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (value_r),
    .raddr_a (front_r),
    .rdata_a (rdata_a),
    .raddr_b (back_addr),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
    if (cmd.load) begin
      out_front_value  <= empty ? EMPTY_VALUE : $signed(rdata_a);
      out_back_value   <= empty ? EMPTY_VALUE : $signed(rdata_b);
      out_entry_count  <= count_r;
      out_push_dropped <= dropped_r;
    end
  end

endmodule : deq_dp

`default_nettype wire
